// File: src/kmuf_pkg.sv
// ----------------------------------------------------------------------------
// kmuf_pkg: shared types and constants
// widths, vertex limits and the controller to datapath command/status bundles
// ----------------------------------------------------------------------------
package kmuf_pkg;

	localparam int VTX      = 64;   // vertex slots, set by the 6-bit endpoint fields
	localparam int VW       = 6;    // vertex index width
	localparam int CFGW     = 7;    // vertex_count register width
	localparam int WW       = 16;   // edge weight width
	localparam int SUMW     = 22;   // total weight width
	localparam int RKW      = 3;    // tree rank width
	localparam int EDGEW    = 2 * VW + WW;
	localparam int UFW      = RKW + VW;
	localparam int DEF_MAX_EDGES = 256;

	typedef struct packed {
		logic         load;        // input transfer this cycle
		logic         init_start;  // clear run totals
		logic         init_step;   // write one fresh forest entry
		logic         scan_start;  // begin a minimum search pass
		logic         scan_step;   // issue one store read
		logic         pick;        // take the best edge of the pass
		logic         find_start;  // load walker with an endpoint
		logic         find_side;   // 0: edge_u, 1: edge_v
		logic         find_rd;     // read link of the walker
		logic         find_chk;    // step walker or latch root
		logic         union_do;    // link the two roots, add weight
		logic         union_rank;  // bump rank of the surviving root
		logic         out_load;    // move totals to the output register
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic all_done;
		logic scan_done;
		logic is_root;
		logic same_root;
		logic rank_eq;
		logic out_full;
	} stat_t;

	function automatic logic [CFGW-1:0] eff_vertices(input logic [CFGW-1:0] n);
		logic [CFGW-1:0] r;
		r = n;
		if (n == '0) r = CFGW'(1);
		if (n > CFGW'(VTX)) r = CFGW'(VTX);
		return r;
	endfunction

endpackage

// File: src/kmuf_datapath.sv
// ----------------------------------------------------------------------------
// kmuf_datapath: edge store, union-find memory and run totals
// minimum search over the store, root walker, linking and output register
// ----------------------------------------------------------------------------
module kmuf_datapath #(
	parameter int MAX_EDGES = kmuf_pkg::DEF_MAX_EDGES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [kmuf_pkg::CFGW-1:0]    cfg_data,
	input  logic [kmuf_pkg::EDGEW-1:0]   in_edge,
	input  kmuf_pkg::cmd_t               cmd,
	output kmuf_pkg::stat_t              stat,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [31:0]                  m_tdata
);

	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VW = kmuf_pkg::VW;
	localparam int WW = kmuf_pkg::WW;
	localparam int RKW = kmuf_pkg::RKW;
	localparam int SUMW = kmuf_pkg::SUMW;

	logic [kmuf_pkg::EDGEW-1:0] edge_mem [MAX_EDGES];
	logic [kmuf_pkg::UFW-1:0]   uf_mem [kmuf_pkg::VTX];

	logic [kmuf_pkg::CFGW-1:0] vcount_q;
	logic [kmuf_pkg::CFGW-1:0] n_eff;
	logic [CW-1:0]             cnt_q, scan_j_q, done_q;
	logic                      drop_q;
	logic [kmuf_pkg::EDGEW-1:0] rd_q;
	logic                      rd_vld_q;
	logic [AW-1:0]             rd_idx_q;
	logic                      best_vld_q, prev_vld_q;
	logic signed [WW-1:0]      best_w_q, prev_w_q, rd_w;
	logic [AW-1:0]             best_idx_q, prev_idx_q;
	logic [VW-1:0]             best_u_q, best_v_q;
	logic [kmuf_pkg::UFW-1:0]  uf_rd_q;
	logic [VW-1:0]             x_q, ra_q, rb_q, init_i_q;
	logic [RKW-1:0]            rka_q, rkb_q;
	logic signed [SUMW-1:0]    sum_q;
	logic [VW-1:0]             chosen_q;
	logic                      out_full_q;
	logic [SUMW-1:0]           out_sum_q;
	logic [VW-1:0]             out_cnt_q;
	logic                      out_drop_q;

	logic                      edge_ok, gt_prev, lt_best;
	logic                      uf_we;
	logic [VW-1:0]             uf_waddr;
	logic [kmuf_pkg::UFW-1:0]  uf_wdata;

	assign n_eff = kmuf_pkg::eff_vertices(vcount_q);
	assign edge_ok = ({1'b0, in_edge[VW-1:0]} < n_eff) &&
	                 ({1'b0, in_edge[2*VW-1:VW]} < n_eff) && (cnt_q < CW'(MAX_EDGES));
	assign rd_w = $signed(rd_q[kmuf_pkg::EDGEW-1:2*VW]);
	assign gt_prev = !prev_vld_q || (rd_w > prev_w_q) ||
	                 ((rd_w == prev_w_q) && (rd_idx_q > prev_idx_q));
	assign lt_best = !best_vld_q || (rd_w < best_w_q);

	// union-find write port
	always_comb begin
		uf_we = 1'b0;
		uf_waddr = init_i_q;
		uf_wdata = {{RKW{1'b0}}, init_i_q};
		if (cmd.init_step) begin
			uf_we = 1'b1;
		end else if (cmd.union_do) begin
			uf_we = 1'b1;
			if (rka_q < rkb_q) begin
				uf_waddr = ra_q;
				uf_wdata = {rka_q, rb_q};
			end else begin
				uf_waddr = rb_q;
				uf_wdata = {rkb_q, ra_q};
			end
		end else if (cmd.union_rank) begin
			uf_we = 1'b1;
			uf_waddr = ra_q;
			uf_wdata = {rka_q + RKW'(1), ra_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && edge_ok) edge_mem[cnt_q[AW-1:0]] <= in_edge;
		if (cmd.scan_step && (scan_j_q != cnt_q)) rd_q <= edge_mem[scan_j_q[AW-1:0]];
		if (uf_we) uf_mem[uf_waddr] <= uf_wdata;
		if (cmd.find_rd) uf_rd_q <= uf_mem[x_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= kmuf_pkg::CFGW'(kmuf_pkg::VTX);
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			rd_vld_q   <= 1'b0;
			scan_j_q   <= '0;
			done_q     <= '0;
			best_vld_q <= 1'b0;
			prev_vld_q <= 1'b0;
			init_i_q   <= '0;
			sum_q      <= '0;
			chosen_q   <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_valid) vcount_q <= cfg_data;
			if (cmd.load) begin
				if (edge_ok) cnt_q <= cnt_q + CW'(1);
				else drop_q <= 1'b1;
			end
			if (cmd.init_start) begin
				init_i_q   <= '0;
				sum_q      <= '0;
				chosen_q   <= '0;
				done_q     <= '0;
				prev_vld_q <= 1'b0;
			end
			if (cmd.init_step) init_i_q <= init_i_q + VW'(1);
			if (cmd.scan_start) begin
				scan_j_q   <= '0;
				best_vld_q <= 1'b0;
			end
			rd_vld_q <= cmd.scan_step && (scan_j_q != cnt_q);
			if (cmd.scan_step && (scan_j_q != cnt_q)) begin
				rd_idx_q <= scan_j_q[AW-1:0];
				scan_j_q <= scan_j_q + CW'(1);
			end
			if (rd_vld_q && gt_prev && lt_best) begin
				best_vld_q <= 1'b1;
				best_w_q   <= rd_w;
				best_idx_q <= rd_idx_q;
				best_u_q   <= rd_q[VW-1:0];
				best_v_q   <= rd_q[2*VW-1:VW];
			end
			if (cmd.pick) begin
				prev_vld_q <= 1'b1;
				prev_w_q   <= best_w_q;
				prev_idx_q <= best_idx_q;
				done_q     <= done_q + CW'(1);
			end
			if (cmd.find_chk) begin
				if (uf_rd_q[VW-1:0] == x_q) begin
					if (cmd.find_side) begin
						rb_q  <= x_q;
						rkb_q <= uf_rd_q[kmuf_pkg::UFW-1:VW];
					end else begin
						ra_q  <= x_q;
						rka_q <= uf_rd_q[kmuf_pkg::UFW-1:VW];
					end
				end else begin
					x_q <= uf_rd_q[VW-1:0];
				end
			end
			// second endpoint starts right after the first root is found
			if (cmd.find_start) x_q <= cmd.find_chk ? best_v_q : best_u_q;
			if (cmd.union_do) begin
				sum_q    <= sum_q + SUMW'(best_w_q);
				chosen_q <= chosen_q + VW'(1);
			end
			if (cmd.out_load) out_full_q <= 1'b1;
			else if (m_tready) out_full_q <= 1'b0;
			if (cmd.out_load) begin
				out_sum_q  <= sum_q;
				out_cnt_q  <= chosen_q;
				out_drop_q <= drop_q;
				cnt_q      <= '0;
				drop_q     <= 1'b0;
			end
		end
	end

	assign stat.init_last = (init_i_q == VW'(kmuf_pkg::VTX - 1));
	assign stat.all_done  = (done_q == cnt_q) || ({1'b0, chosen_q} == n_eff - 1'b1);
	assign stat.scan_done = (scan_j_q == cnt_q) && !rd_vld_q;
	assign stat.is_root   = (uf_rd_q[VW-1:0] == x_q);
	assign stat.same_root = (ra_q == rb_q);
	assign stat.rank_eq   = (rka_q == rkb_q);
	assign stat.out_full  = out_full_q;

	assign m_tvalid = out_full_q;
	assign m_tdata  = {3'b000, out_drop_q, out_cnt_q, out_sum_q};

endmodule

// File: src/kmuf_ctrl.sv
// ----------------------------------------------------------------------------
// kmuf_ctrl: sequencer for load, forest reset, edge selection and union
// ----------------------------------------------------------------------------
module kmuf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tlast,
	output logic            s_tready,
	input  kmuf_pkg::stat_t stat,
	output kmuf_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_INIT   = 4'd1;
	localparam logic [3:0] ST_PASS   = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_FRD    = 4'd4;
	localparam logic [3:0] ST_FCHK   = 4'd5;
	localparam logic [3:0] ST_UNION  = 4'd6;
	localparam logic [3:0] ST_RANK   = 4'd7;
	localparam logic [3:0] ST_FINISH = 4'd8;

	logic [3:0] state_q, state_d;
	logic       side_q, side_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		side_d   = side_q;
		s_tready = 1'b0;
		cmd.find_side = side_q;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					cmd.init_start = 1'b1;
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) state_d = ST_PASS;
			end
			ST_PASS: begin
				if (stat.all_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					cmd.pick = 1'b1;
					cmd.find_start = 1'b1;
					cmd.find_side = 1'b0;
					side_d = 1'b0;
					state_d = ST_FRD;
				end
			end
			ST_FRD: begin
				cmd.find_rd = 1'b1;
				state_d = ST_FCHK;
			end
			ST_FCHK: begin
				cmd.find_chk = 1'b1;
				if (!stat.is_root) begin
					state_d = ST_FRD;
				end else if (!side_q) begin
					cmd.find_start = 1'b1;
					side_d = 1'b1;
					state_d = ST_FRD;
				end else begin
					state_d = ST_UNION;
				end
			end
			ST_UNION: begin
				if (stat.same_root) begin
					state_d = ST_PASS;
				end else begin
					cmd.union_do = 1'b1;
					state_d = stat.rank_eq ? ST_RANK : ST_PASS;
				end
			end
			ST_RANK: begin
				cmd.union_rank = 1'b1;
				state_d = ST_PASS;
			end
			ST_FINISH: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

endmodule

// File: src/kruskal_mst_union_find_unit.sv
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_unit: minimum spanning tree/forest over an edge stream
// stores edges, then picks them in ascending weight and joins trees via union-find
// ----------------------------------------------------------------------------
// edges load at one per cycle; the last edge starts the run and holds off input
// run: forest reset of all 64 vertex slots, then per edge taken from the store a search pass
//   over every stored edge, a root walk from each endpoint and, for two distinct roots, a link
// each search pass reads the stored edges one at a time through the single store port
// result sits in an output register; loading resumes once it is placed there
// asynchronous active-low reset: store empty, drop flag clear, vertex_count = 64
module kruskal_mst_union_find_unit #(
	parameter int MAX_EDGES = kmuf_pkg::DEF_MAX_EDGES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// vertex_count register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [kmuf_pkg::CFGW-1:0] cfg_data,
	// edge input
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // edge_u[5:0], edge_v[11:6], edge_weight[27:12]
	input  logic                      s_tlast,   // last_edge
	// result output
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata    // tree_sum[21:0], edges_chosen[27:22], edges_dropped[28]
);

	kmuf_pkg::cmd_t  cmd;
	kmuf_pkg::stat_t stat;

	// register writes must arrive only while idle; the block does not enforce this and always takes them
	assign cfg_ready = 1'b1;

	kmuf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// edge store, union-find memory, totals and output register
	kmuf_datapath #(
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_edge   (s_tdata[kmuf_pkg::EDGEW-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
